// ===== hw/rtl/swrm_pkg.sv =====
package swrm_pkg;

	localparam int DEPTH_DEF = 16;
	localparam int DATA_WIDTH_DEF = 32;

	localparam int FUNC_WIDTH = 3;

	localparam logic [FUNC_WIDTH-1:0] FN_PUSH    = 3'd0;
	localparam logic [FUNC_WIDTH-1:0] FN_POP     = 3'd1;
	localparam logic [FUNC_WIDTH-1:0] FN_INSERT  = 3'd2;
	localparam logic [FUNC_WIDTH-1:0] FN_REVERSE = 3'd3;
	localparam logic [FUNC_WIDTH-1:0] FN_QUERY   = 3'd4;

	// Per-operation control and status handed from the pointer logic to the result stage.
	typedef struct packed {
		logic wr_en;
		logic top_hit;
		logic mid_hit;
		logic is_empty;
		logic overflow;
		logic underflow;
	} swrm_ctl_t;

endpackage

// ===== hw/rtl/swrm_op_if.sv =====
interface swrm_op_if
	import swrm_pkg::*;
#(
	parameter int DATA_WIDTH = DATA_WIDTH_DEF
);
	logic                         valid;
	logic                         ready;
	logic [FUNC_WIDTH-1:0]        func;
	logic signed [DATA_WIDTH-1:0] value;

	modport source (output valid, output func, output value, input ready);
	modport sink (input valid, input func, input value, output ready);
endinterface

// ===== hw/rtl/swrm_res_if.sv =====
interface swrm_res_if
	import swrm_pkg::*;
#(
	parameter int DATA_WIDTH = DATA_WIDTH_DEF,
	parameter int CNT_WIDTH = $clog2(DEPTH_DEF + 1)
);
	logic                         valid;
	logic                         ready;
	logic signed [DATA_WIDTH-1:0] top_value;
	logic signed [DATA_WIDTH-1:0] middle_value;
	logic [CNT_WIDTH-1:0]         item_count;
	logic                         is_empty;
	logic                         overflow;
	logic                         underflow;

	modport source (
		output valid, output top_value, output middle_value, output item_count,
		output is_empty, output overflow, output underflow, input ready
	);
	modport sink (
		input valid, input top_value, input middle_value, input item_count,
		input is_empty, input overflow, input underflow, output ready
	);
endinterface

// ===== hw/rtl/swrm_mem.sv =====
module swrm_mem
	import swrm_pkg::*;
#(
	parameter int DEPTH = DEPTH_DEF,
	parameter int DATA_WIDTH = DATA_WIDTH_DEF,
	parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic                  clk,
	input  logic                  we,
	input  logic [AW-1:0]         waddr,
	input  logic [DATA_WIDTH-1:0] wdata,
	input  logic                  re,
	input  logic [AW-1:0]         raddr_a,
	input  logic [AW-1:0]         raddr_b,
	output logic [DATA_WIDTH-1:0] rdata_a,
	output logic [DATA_WIDTH-1:0] rdata_b
);
	logic [DATA_WIDTH-1:0] mem [DEPTH];
	logic [DATA_WIDTH-1:0] rd_a_q;
	logic [DATA_WIDTH-1:0] rd_b_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Reads return the old word on an address collision; the caller forwards the new one.
	always_ff @(posedge clk) begin
		if (re) begin
			rd_a_q <= mem[raddr_a];
			rd_b_q <= mem[raddr_b];
		end
	end

	assign rdata_a = rd_a_q;
	assign rdata_b = rd_b_q;
endmodule

// ===== hw/rtl/swrm_ctrl.sv =====
module swrm_ctrl
	import swrm_pkg::*;
#(
	parameter int DEPTH = DEPTH_DEF,
	parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
	parameter int CW = $clog2(DEPTH + 1)
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  advance,
	input  logic [FUNC_WIDTH-1:0] func,
	output logic [AW-1:0]         wr_addr,
	output logic [AW-1:0]         top_addr,
	output logic [AW-1:0]         mid_addr,
	output logic [CW-1:0]         count,
	output swrm_ctl_t             ctl
);
	localparam logic [AW:0] DEPTH_W = (AW + 1)'(DEPTH);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	logic [AW-1:0] bp_q;
	logic [CW-1:0] cnt_q;
	logic          rev_q;

	logic [AW-1:0] bp_n;
	logic [CW-1:0] cnt_n;
	logic          rev_n;
	logic          wr_en;
	logic          ovf;
	logic          udf;
	logic          full;

	// Ring position idx steps away from base: upward when dir is 0, downward when 1.
	function automatic logic [AW-1:0] ring_pos(input logic [AW-1:0] base, input logic dir,
			input logic [AW-1:0] idx);
		logic [AW:0] s;
		if (!dir) begin
			s = {1'b0, base} + {1'b0, idx};
			if (s >= DEPTH_W) begin
				s = s - DEPTH_W;
			end
		end else begin
			s = {1'b0, base} - {1'b0, idx};
			if (s[AW]) begin
				s = s + DEPTH_W;
			end
		end
		return s[AW-1:0];
	endfunction

	always_comb begin
		bp_n    = bp_q;
		cnt_n   = cnt_q;
		rev_n   = rev_q;
		wr_en   = 1'b0;
		ovf     = 1'b0;
		udf     = 1'b0;
		full    = (cnt_q == FULL_CNT);
		wr_addr = ring_pos(bp_q, rev_q, AW'(cnt_q));
		unique case (func)
			FN_PUSH: begin
				if (full) begin
					ovf = 1'b1;
				end else begin
					wr_en = 1'b1;
					cnt_n = cnt_q + CW'(1);
				end
			end
			FN_POP: begin
				if (cnt_q == '0) begin
					udf = 1'b1;
				end else begin
					cnt_n = cnt_q - CW'(1);
				end
			end
			FN_INSERT: begin
				if (full) begin
					ovf = 1'b1;
				end else begin
					// The bottom moves one slot against the current direction.
					bp_n    = ring_pos(bp_q, ~rev_q, AW'(1));
					wr_addr = bp_n;
					wr_en   = 1'b1;
					cnt_n   = cnt_q + CW'(1);
				end
			end
			FN_REVERSE: begin
				if (cnt_q != '0) begin
					bp_n  = ring_pos(bp_q, rev_q, AW'(cnt_q - CW'(1)));
					rev_n = ~rev_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign top_addr = ring_pos(bp_n, rev_n, AW'(cnt_n - CW'(1)));
	assign mid_addr = ring_pos(bp_n, rev_n, AW'(cnt_n >> 1));
	assign count    = cnt_n;

	assign ctl.wr_en     = wr_en;
	assign ctl.top_hit   = wr_en && (top_addr == wr_addr);
	assign ctl.mid_hit   = wr_en && (mid_addr == wr_addr);
	assign ctl.is_empty  = (cnt_n == '0);
	assign ctl.overflow  = ovf;
	assign ctl.underflow = udf;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bp_q  <= '0;
			cnt_q <= '0;
			rev_q <= 1'b0;
		end else if (advance) begin
			bp_q  <= bp_n;
			cnt_q <= cnt_n;
			rev_q <= rev_n;
		end
	end
endmodule

// ===== hw/rtl/stack_with_reverse_and_middle.sv =====
// A result word appears in the cycle after its operation word is accepted.
// Throughput: one operation per cycle while res.ready is high; ring pointers, the
// two-read store and result register advance together; none waits on the one before.
// Reset (arst_n low, asynchronous) empties the stack and clears the result valid;
// the store itself is not cleared and needs no sweep after reset.
module stack_with_reverse_and_middle
	import swrm_pkg::*;
#(
	parameter int DEPTH = DEPTH_DEF,
	parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
	input logic         clk,
	input logic         arst_n,
	swrm_op_if.sink     op,
	swrm_res_if.source  res
);
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic                  accept;
	logic [AW-1:0]         wr_addr;
	logic [AW-1:0]         top_addr;
	logic [AW-1:0]         mid_addr;
	logic [CW-1:0]         count;
	swrm_ctl_t             ctl;
	logic [DATA_WIDTH-1:0] rd_top;
	logic [DATA_WIDTH-1:0] rd_mid;

	logic                  valid_s1;
	swrm_ctl_t             ctl_s1;
	logic [CW-1:0]         count_s1;
	logic [DATA_WIDTH-1:0] wdata_s1;

	assign op.ready = !valid_s1 || res.ready;
	assign accept   = op.valid && op.ready;

	swrm_ctrl #(
		.DEPTH (DEPTH),
		.AW    (AW),
		.CW    (CW)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.advance  (accept),
		.func     (op.func),
		.wr_addr  (wr_addr),
		.top_addr (top_addr),
		.mid_addr (mid_addr),
		.count    (count),
		.ctl      (ctl)
	);

	swrm_mem #(
		.DEPTH      (DEPTH),
		.DATA_WIDTH (DATA_WIDTH),
		.AW         (AW)
	) u_mem (
		.clk     (clk),
		.we      (accept && ctl.wr_en),
		.waddr   (wr_addr),
		.wdata   (op.value),
		.re      (accept),
		.raddr_a (top_addr),
		.raddr_b (mid_addr),
		.rdata_a (rd_top),
		.rdata_b (rd_mid)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (op.ready) begin
			valid_s1 <= op.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ctl_s1   <= ctl;
			count_s1 <= count;
			wdata_s1 <= op.value;
		end
	end

	// An empty stack reports all ones (minus one) for both words. A word written by the
	// same operation is taken from the forwarding register, not from the store.
	assign res.valid        = valid_s1;
	assign res.top_value    = ctl_s1.is_empty ? '1 : (ctl_s1.top_hit ? wdata_s1 : rd_top);
	assign res.middle_value = ctl_s1.is_empty ? '1 : (ctl_s1.mid_hit ? wdata_s1 : rd_mid);
	assign res.item_count   = count_s1;
	assign res.is_empty     = ctl_s1.is_empty;
	assign res.overflow     = ctl_s1.overflow;
	assign res.underflow    = ctl_s1.underflow;
endmodule
